// ----- rtl/ndpp_pkg.sv -----
// ----------------------------------------------------------------------------
// ndpp_pkg
// shared types and constants of the null-data push parser
// ----------------------------------------------------------------------------
package ndpp_pkg;

    // script codes
    localparam logic [7:0] ND_MARKER      = 8'h6a;
    localparam logic [7:0] OP_LEN1        = 8'h4c;
    localparam logic [7:0] OP_LEN2        = 8'h4d;
    localparam logic [7:0] OP_LEN4        = 8'h4e;
    localparam logic [7:0] OP_CONST_FIRST = 8'h4f;
    localparam logic [7:0] OP_CONST_LAST  = 8'h60;

    // push kinds as reported in op_kind
    localparam logic [2:0] KIND_IMM   = 3'd0;
    localparam logic [2:0] KIND_PD1   = 3'd1;
    localparam logic [2:0] KIND_PD2   = 3'd2;
    localparam logic [2:0] KIND_PD4   = 3'd3;
    localparam logic [2:0] KIND_CONST = 3'd4;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int IDX_W           = 16;

    // result queue, depth must be a power of two
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
    // slots kept free: two items in flight, up to two results each
    localparam int FIFO_SLACK = 4;

    typedef struct packed {
        logic             op_done;
        logic [2:0]       op_kind;
        logic [4:0]       const_index;
        logic [31:0]      data_length;
        logic [IDX_W-1:0] op_index;
        logic             is_final;
        logic             null_data_valid;
        logic [IDX_W-1:0] op_count;
    } t_result;

    // results caused by one script byte
    typedef struct packed {
        logic    push_vld;
        t_result push;
        logic    fin_vld;
        t_result fin;
    } t_step_out;

endpackage

// ----- rtl/ndpp_in_if.sv -----
// ----------------------------------------------------------------------------
// ndpp_in_if
// script byte channel
// ----------------------------------------------------------------------------
interface ndpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] script_byte;
    logic       last_byte;

    modport source (output valid, output script_byte, output last_byte, input ready);
    modport sink   (input valid, input script_byte, input last_byte, output ready);
endinterface

// ----- rtl/ndpp_res_if.sv -----
// ----------------------------------------------------------------------------
// ndpp_res_if
// parse result channel
// ----------------------------------------------------------------------------
interface ndpp_res_if;
    logic        valid;
    logic        ready;
    logic        op_done;
    logic [2:0]  op_kind;
    logic [4:0]  const_index;
    logic [31:0] data_length;
    logic [15:0] op_index;
    logic        is_final;
    logic        null_data_valid;
    logic [15:0] op_count;

    modport source (
        output valid, output op_done, output op_kind, output const_index,
        output data_length, output op_index, output is_final,
        output null_data_valid, output op_count, input ready
    );
    modport sink (
        input valid, input op_done, input op_kind, input const_index,
        input data_length, input op_index, input is_final,
        input null_data_valid, input op_count, output ready
    );
endinterface

// ----- rtl/null_data_push_parser_core.sv -----
// ----------------------------------------------------------------------------
// null_data_push_parser_core
// null-data locking script parser, one script byte per item
// ----------------------------------------------------------------------------
// The block takes a locking script one byte per item, the last byte marked,
// and checks that it is a null-data script: the 0x6a marker followed only by
// push operations. For each completed push it gives one result with the
// push kind, the constant index and the data length; on the last byte it
// gives an end-of-script result with the validity and the push count (0 when
// the script is bad). A byte can be taken in every cycle while the result
// queue has room. Each byte goes through an input register and the
// combinational parser logic, and its results land in an eight-entry
// result queue, from which they are offered. A byte that completes a push
// and also ends the script gives two results, which leave one after the
// other, push result first. Input ready drops while the queue holds more
// than four results, which is the only source of back-pressure.
// ----------------------------------------------------------------------------
module null_data_push_parser_core #(
    parameter int COUNT_WIDTH = ndpp_pkg::COUNT_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ndpp_in_if.sink    i_in,
    ndpp_res_if.source o_res
);
    import ndpp_pkg::*;

    // input register stage
    logic       r_in_vld;
    logic [7:0] r_byte;
    logic       r_last;

    logic       room;
    logic       in_take;
    t_step_out  step;

    assign i_in.ready = room;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= in_take;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte <= i_in.script_byte;
            r_last <= i_in.last_byte;
        end
    end

    // parser state and per-byte decode
    ndpp_parse #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_byte  (r_byte),
        .i_last  (r_last),
        .o_step  (step)
    );

    // result queue doubles as the output register
    ndpp_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_room  (room),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    // every taken byte reaches the parser in the next cycle
    a_in_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_vld)
        else $error("taken byte lost before the parser");
`endif

endmodule

// ----- rtl/ndpp_parse.sv -----
// ----------------------------------------------------------------------------
// ndpp_parse
// per-byte parser state update, gives push and end-of-script results
// ----------------------------------------------------------------------------
module ndpp_parse #(
    parameter int COUNT_WIDTH = ndpp_pkg::COUNT_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_vld,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output ndpp_pkg::t_step_out   o_step
);
    import ndpp_pkg::*;

    localparam logic [1:0] PH_MARK = 2'd0;
    localparam logic [1:0] PH_CODE = 2'd1;
    localparam logic [1:0] PH_LEN  = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    logic [1:0]             r_phase, n_phase;
    logic [1:0]             r_len_left, n_len_left;
    logic [1:0]             r_len_pos, n_len_pos;
    logic [2:0]             r_kind, n_kind;
    logic [31:0]            r_push_len, n_push_len;
    logic [31:0]            r_data_rem, n_data_rem;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_failed, n_failed;

    logic                   push_vld;
    logic [2:0]             push_kind;
    logic [4:0]             push_cidx;
    logic [31:0]            push_len;
    logic [31:0]            len_acc;
    logic                   fin_ok;
    logic [COUNT_WIDTH+IDX_W-1:0] cur_wide, nxt_wide;

    assign len_acc  = r_push_len | ({24'b0, i_byte} << {r_len_pos, 3'b000});
    assign cur_wide = {{IDX_W{1'b0}}, r_count};

    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_len_pos  = r_len_pos;
        n_kind     = r_kind;
        n_push_len = r_push_len;
        n_data_rem = r_data_rem;
        n_count    = r_count;
        n_failed   = r_failed;
        push_vld   = 1'b0;
        push_kind  = KIND_IMM;
        push_cidx  = '0;
        push_len   = '0;
        fin_ok     = 1'b0;
        nxt_wide   = '0;

        if (i_vld && !r_failed) begin
            case (r_phase)
                PH_MARK: begin
                    if (i_byte != ND_MARKER) begin
                        n_failed = 1'b1;
                    end else begin
                        n_phase = PH_CODE;
                    end
                end
                PH_CODE: begin
                    if (i_byte > OP_CONST_LAST) begin
                        n_failed = 1'b1;
                    end else if (i_byte inside {[OP_CONST_FIRST:OP_CONST_LAST]}) begin
                        push_vld  = 1'b1;
                        push_kind = KIND_CONST;
                        push_cidx = 5'(i_byte - OP_CONST_FIRST);
                    end else if (i_byte < OP_LEN1) begin
                        if (i_byte == 8'd0) begin
                            push_vld = 1'b1;
                        end else begin
                            n_kind     = KIND_IMM;
                            n_push_len = {24'b0, i_byte};
                            n_data_rem = {24'b0, i_byte};
                            n_phase    = PH_DATA;
                        end
                    end else begin
                        n_kind     = 3'(i_byte - (OP_LEN1 - 8'd1));
                        n_len_left = (i_byte == OP_LEN1) ? 2'd0 :
                                     (i_byte == OP_LEN2) ? 2'd1 : 2'd3;
                        n_len_pos  = 2'd0;
                        n_push_len = '0;
                        n_phase    = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_push_len = len_acc;
                    n_len_pos  = r_len_pos + 2'd1;
                    if (r_len_left == 2'd0) begin
                        if (len_acc == 32'd0) begin
                            push_vld  = 1'b1;
                            push_kind = r_kind;
                        end else begin
                            n_data_rem = len_acc;
                            n_phase    = PH_DATA;
                        end
                    end else begin
                        n_len_left = r_len_left - 2'd1;
                    end
                end
                PH_DATA: begin
                    n_data_rem = r_data_rem - 32'd1;
                    if (r_data_rem == 32'd1) begin
                        push_vld  = 1'b1;
                        push_kind = r_kind;
                        push_len  = r_push_len;
                    end
                end
                default: begin
                    n_failed = 1'b1;
                end
            endcase
        end

        // a completed push goes back to the code phase, count saturates
        if (push_vld) begin
            n_phase = PH_CODE;
            if (r_count != {COUNT_WIDTH{1'b1}}) begin
                n_count = r_count + 1'b1;
            end
        end

        if (i_vld && i_last) begin
            fin_ok     = !n_failed && (n_phase == PH_CODE);
            nxt_wide   = {{IDX_W{1'b0}}, n_count};
            n_phase    = PH_MARK;
            n_len_left = '0;
            n_len_pos  = '0;
            n_kind     = '0;
            n_push_len = '0;
            n_data_rem = '0;
            n_count    = '0;
            n_failed   = 1'b0;
        end
    end

    always_comb begin
        o_step.push_vld             = i_vld && push_vld;
        o_step.push.op_done         = 1'b1;
        o_step.push.op_kind         = push_kind;
        o_step.push.const_index     = push_cidx;
        o_step.push.data_length     = push_len;
        o_step.push.op_index        = cur_wide[IDX_W-1:0];
        o_step.push.is_final        = 1'b0;
        o_step.push.null_data_valid = 1'b0;
        o_step.push.op_count        = '0;

        o_step.fin_vld              = i_vld && i_last;
        o_step.fin.op_done          = 1'b0;
        o_step.fin.op_kind          = KIND_IMM;
        o_step.fin.const_index      = '0;
        o_step.fin.data_length      = '0;
        o_step.fin.op_index         = '0;
        o_step.fin.is_final         = 1'b1;
        o_step.fin.null_data_valid  = fin_ok;
        o_step.fin.op_count         = fin_ok ? nxt_wide[IDX_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MARK;
            r_len_left <= '0;
            r_len_pos  <= '0;
            r_kind     <= '0;
            r_push_len <= '0;
            r_data_rem <= '0;
            r_count    <= '0;
            r_failed   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_len_left <= n_len_left;
            r_len_pos  <= n_len_pos;
            r_kind     <= n_kind;
            r_push_len <= n_push_len;
            r_data_rem <= n_data_rem;
            r_count    <= n_count;
            r_failed   <= n_failed;
        end
    end

`ifndef SYNTHESIS
    // no push is reported once the script is known bad
    a_no_push_after_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step.push_vld |-> !r_failed)
        else $error("push result from a failed script");
`endif

endmodule

// ----- rtl/ndpp_res_fifo.sv -----
// ----------------------------------------------------------------------------
// ndpp_res_fifo
// result queue, takes up to two results per cycle, gives one per handshake
// ----------------------------------------------------------------------------
module ndpp_res_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ndpp_pkg::t_step_out  i_step,
    output logic                 o_room,
    ndpp_res_if.source           o_res
);
    import ndpp_pkg::*;

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count, n_count;
    logic [FIFO_PTR_W-1:0]  wr_ptr1;
    logic [1:0]             wr_n;
    logic                   pop;
    t_result                wr0_data;
    t_result                head;

    assign wr_n     = {1'b0, i_step.push_vld} + {1'b0, i_step.fin_vld};
    assign wr0_data = i_step.push_vld ? i_step.push : i_step.fin;
    assign wr_ptr1  = r_wr_ptr + 1'b1;
    assign pop      = o_res.valid && o_res.ready;
    assign o_room   = r_count <= FIFO_CNT_W'(FIFO_DEPTH - FIFO_SLACK);

    assign n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(wr_n);
    assign n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
    assign n_count  = r_count + FIFO_CNT_W'(wr_n) - FIFO_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (wr_n != 2'd0) begin
            r_mem[r_wr_ptr] <= wr0_data;
        end
        // end-of-script result behind a push of the same byte
        if (wr_n == 2'd2) begin
            r_mem[wr_ptr1] <= i_step.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign head                  = r_mem[r_rd_ptr];
    assign o_res.valid           = r_count != '0;
    assign o_res.op_done         = head.op_done;
    assign o_res.op_kind         = head.op_kind;
    assign o_res.const_index     = head.const_index;
    assign o_res.data_length     = head.data_length;
    assign o_res.op_index        = head.op_index;
    assign o_res.is_final        = head.is_final;
    assign o_res.null_data_valid = head.null_data_valid;
    assign o_res.op_count        = head.op_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({2'b0, r_count} + {{FIFO_CNT_W{1'b0}}, wr_n}) <= (FIFO_CNT_W + 2)'(FIFO_DEPTH))
        else $error("result queue overflow");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FIFO_CNT_W'(FIFO_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the null-data push parser core
// ----------------------------------------------------------------------------
// Scripts are fed one byte per item. They start with a directed set: marker
// only, wrong marker, every push kind, zero-length pushes, bad codes and cut
// scripts. After that come random scripts, mostly well-formed with random
// content and some broken. An in-bench model of the parser predicts every
// push result and every end-of-script result. Each result that leaves the
// block is checked field by field against the oldest prediction. Sender gaps
// and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ndpp_pkg::*;

    localparam int COUNT_W     = COUNT_WIDTH_DEF;
    localparam int IDLE_LIMIT  = 4000;   // cycles with no item moving on either side
    localparam int DRAIN_WAIT  = 20;     // cycles after the last expected result
    localparam int PHASE_ITEMS = 320;    // parsed bytes per random phase

    // parser phase as tracked by the bench model
    typedef enum logic [1:0] {
        AWAIT_MARKER,
        AWAIT_CODE,
        IN_LENGTH,
        IN_DATA
    } t_parse_phase;

    // ------------------------------------------------------------------------
    // scoreboard: model of the parser plus the queue of predicted results
    // ------------------------------------------------------------------------
    class t_script_board;
        t_result              predicted_results[$];
        int unsigned          mismatches;
        t_parse_phase         phase;
        logic [1:0]           len_left;
        logic [1:0]           len_pos;
        logic [2:0]           cur_kind;
        logic [31:0]          push_len;
        logic [31:0]          data_left;
        logic [COUNT_W-1:0]   push_count;
        bit                   failed;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            phase      = AWAIT_MARKER;
            len_left   = '0;
            len_pos    = '0;
            cur_kind   = KIND_IMM;
            push_len   = '0;
            data_left  = '0;
            push_count = '0;
            failed     = 0;
        endfunction

        function void complete_push(logic [2:0] kind, logic [4:0] cidx, logic [31:0] len);
            t_result r;
            r             = '0;
            r.op_done     = 1'b1;
            r.op_kind     = kind;
            r.const_index = cidx;
            r.data_length = len;
            r.op_index    = push_count[IDX_W-1:0];
            predicted_results.push_back(r);
            if (push_count != '1)
                push_count = push_count + 1'b1;
            phase = AWAIT_CODE;
        endfunction

        // returns 1 when the byte was parsed rather than ignored
        function bit note_byte(logic [7:0] b, logic is_last);
            t_result fin;
            bit      parsed;
            bit      ok;
            parsed = !failed;
            if (!failed) begin
                case (phase)
                    AWAIT_MARKER: begin
                        if (b != ND_MARKER)
                            failed = 1;
                        else
                            phase = AWAIT_CODE;
                    end
                    AWAIT_CODE: begin
                        if (b > OP_CONST_LAST) begin
                            failed = 1;
                        end else if (b >= OP_CONST_FIRST) begin
                            complete_push(KIND_CONST, 5'(b - OP_CONST_FIRST), '0);
                        end else if (b < OP_LEN1) begin
                            if (b == 8'd0) begin
                                complete_push(KIND_IMM, '0, '0);
                            end else begin
                                cur_kind  = KIND_IMM;
                                push_len  = {24'd0, b};
                                data_left = {24'd0, b};
                                phase     = IN_DATA;
                            end
                        end else begin
                            case (b)
                                OP_LEN1: begin
                                    cur_kind = KIND_PD1;
                                    len_left = 2'd0;
                                end
                                OP_LEN2: begin
                                    cur_kind = KIND_PD2;
                                    len_left = 2'd1;
                                end
                                default: begin
                                    cur_kind = KIND_PD4;
                                    len_left = 2'd3;
                                end
                            endcase
                            len_pos  = '0;
                            push_len = '0;
                            phase    = IN_LENGTH;
                        end
                    end
                    IN_LENGTH: begin
                        push_len = push_len | ({24'd0, b} << {len_pos, 3'b000});
                        len_pos  = len_pos + 2'd1;
                        if (len_left == 2'd0) begin
                            if (push_len == '0) begin
                                complete_push(cur_kind, '0, '0);
                            end else begin
                                data_left = push_len;
                                phase     = IN_DATA;
                            end
                        end else begin
                            len_left = len_left - 2'd1;
                        end
                    end
                    default: begin
                        data_left = data_left - 1;
                        if (data_left == '0)
                            complete_push(cur_kind, '0, push_len);
                    end
                endcase
            end
            if (is_last) begin
                ok                  = !failed && (phase == AWAIT_CODE);
                fin                 = '0;
                fin.is_final        = 1'b1;
                fin.null_data_valid = ok;
                fin.op_count        = ok ? push_count[IDX_W-1:0] : '0;
                predicted_results.push_back(fin);
                restart();
            end
            return parsed;
        endfunction

        function string describe(t_result r);
            return {$sformatf("done=%0b kind=%0d cidx=%0d len=%0d ", r.op_done, r.op_kind,
                              r.const_index, r.data_length),
                    $sformatf("idx=%0d fin=%0b valid=%0b cnt=%0d", r.op_index, r.is_final,
                              r.null_data_valid, r.op_count)};
        endfunction

        function void check_result(t_result got);
            t_result want;
            bit      bad;
            if (predicted_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %s", describe(got));
                return;
            end
            want = predicted_results.pop_front();
            bad  = (got.op_done !== want.op_done) || (got.op_kind !== want.op_kind)
                || (got.const_index !== want.const_index)
                || (got.data_length !== want.data_length)
                || (got.op_index !== want.op_index) || (got.is_final !== want.is_final)
                || (got.null_data_valid !== want.null_data_valid)
                || (got.op_count !== want.op_count);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected %s", describe(want));
                    $display("          actual   %s", describe(got));
                end
            end
        endfunction

        function int unsigned outstanding();
            return predicted_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    ndpp_in_if  in_ch ();
    ndpp_res_if res_ch ();

    null_data_push_parser_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    t_script_board board = new();

    int          send_idle_pct;   // chance in a hundred of a sender gap cycle
    int          recv_stall_pct;  // chance in a hundred of a receiver stall cycle
    int unsigned parsed_items;    // bytes the parser actually looked at
    int unsigned idle_cycles = 0;
    logic [7:0]  script_q[$];     // script being assembled for sending

    // ------------------------------------------------------------------------
    // result side: check accepted results, random stalls, watchdog
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        // values seen here are the ones from before the edge
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.op_done         = res_ch.op_done;
            got.op_kind         = res_ch.op_kind;
            got.const_index     = res_ch.const_index;
            got.data_length     = res_ch.data_length;
            got.op_index        = res_ch.op_index;
            got.is_final        = res_ch.is_final;
            got.null_data_valid = res_ch.null_data_valid;
            got.op_count        = res_ch.op_count;
            board.check_result(got);
        end
        res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

        // watchdog: counts cycles in which no item moves on either side
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // byte side
    // ------------------------------------------------------------------------
    // one byte: optional gap with valid low, then hold until taken
    task automatic send_byte(logic [7:0] b, logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.script_byte <= b;
        in_ch.last_byte   <= is_last;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        if (board.note_byte(b, is_last))
            parsed_items++;
    endtask

    task automatic send_script();
        for (int i = 0; i < script_q.size(); i++)
            send_byte(script_q[i], i == script_q.size() - 1);
        script_q.delete();
    endtask

    // data bytes of a push, random content
    task automatic add_data(int unsigned len);
        repeat (len)
            script_q.push_back(8'($urandom));
    endtask

    // one well-formed push of a random kind, mostly short
    task automatic add_push();
        int unsigned pick;
        int unsigned len;
        bit          rare;
        pick = $urandom_range(0, 99);
        rare = ($urandom_range(0, 49) == 0);
        if (pick < 30) begin
            // immediate push, now and then the longest one
            len = rare ? int'(OP_LEN1) - 1 : $urandom_range(0, 8);
            script_q.push_back(8'(len));
            add_data(len);
        end else if (pick < 55) begin
            script_q.push_back(8'($urandom_range(OP_CONST_FIRST, OP_CONST_LAST)));
        end else if (pick < 70) begin
            len = rare ? 255 : $urandom_range(0, 6);
            script_q.push_back(OP_LEN1);
            script_q.push_back(8'(len));
            add_data(len);
        end else if (pick < 85) begin
            len = rare ? $urandom_range(256, 300) : $urandom_range(0, 6);
            script_q.push_back(OP_LEN2);
            script_q.push_back(len[7:0]);
            script_q.push_back(len[15:8]);
            add_data(len);
        end else begin
            len = rare ? $urandom_range(256, 270) : $urandom_range(0, 6);
            script_q.push_back(OP_LEN4);
            script_q.push_back(len[7:0]);
            script_q.push_back(len[15:8]);
            script_q.push_back(len[23:16]);
            script_q.push_back(len[31:24]);
            add_data(len);
        end
    endtask

    // random script: mostly well-formed, some noise, wrong marker, cut or bad code
    task automatic build_script();
        int unsigned pick;
        int unsigned cut;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 8))
                script_q.push_back(8'($urandom));
        end else begin
            script_q.push_back(ND_MARKER);
            repeat ($urandom_range(0, 6))
                add_push();
            if (pick < 16) begin
                script_q[0] = 8'($urandom);
            end else if (pick < 26 && script_q.size() > 1) begin
                // may end inside a length field or inside data
                cut = $urandom_range(1, script_q.size() - 1);
                while (script_q.size() > cut)
                    void'(script_q.pop_back());
            end else if (pick < 32) begin
                script_q.push_back(8'($urandom_range(int'(OP_CONST_LAST) + 1, 255)));
                add_push();
            end
        end
    endtask

    task automatic run_phase(int send_pct, int stall_pct);
        int unsigned start;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        start          = parsed_items;
        while (parsed_items - start < PHASE_ITEMS) begin
            build_script();
            send_script();
        end
    endtask

    task automatic queue_bytes(logic [7:0] bytes[]);
        foreach (bytes[i])
            script_q.push_back(bytes[i]);
    endtask

    initial begin
        in_ch.valid       <= 1'b0;
        in_ch.script_byte <= '0;
        in_ch.last_byte   <= 1'b0;
        i_rst_n           <= 1'b0;
        parsed_items       = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed scripts, no idling
        // marker only: valid with no pushes
        queue_bytes('{ND_MARKER});
        send_script();
        // wrong marker
        queue_bytes('{8'hff});
        send_script();
        // code above the constants, then a byte that is ignored
        queue_bytes('{ND_MARKER, 8'hff, OP_CONST_FIRST});
        send_script();
        // immediate zero, both constant extremes, immediate one, one-byte
        // length push completing on the last byte together with the summary
        queue_bytes('{ND_MARKER, 8'h00, OP_CONST_FIRST, OP_CONST_LAST, 8'h01, 8'hff,
                      OP_LEN1, 8'h01, 8'h00});
        send_script();
        // zero-length pushes with 1, 2 and 4 length bytes, each completing on its length
        queue_bytes('{ND_MARKER, OP_LEN1, 8'h00, OP_LEN2, 8'h00, 8'h00,
                      OP_LEN4, 8'h00, 8'h00, 8'h00, 8'h00});
        send_script();
        // largest length, script ends right after it
        queue_bytes('{ND_MARKER, OP_LEN4, 8'hff, 8'hff, 8'hff, 8'hff});
        send_script();
        // script ends in data
        queue_bytes('{ND_MARKER, 8'h03, 8'h5a});
        send_script();

        // random scripts under changing flow control
        run_phase(0, 0);
        run_phase(81, 0);
        run_phase(0, 81);
        run_phase(34, 34);
        in_ch.valid <= 1'b0;

        // drain, then give the block time to show any extra result
        while (board.outstanding() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
